// ===== rtl/ivm_pkg.sv =====
// Package for the interval value map: payload structs, entry type and the
// control group that the sequencer drives into each table cell. No dependencies.
package ivm_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 8;

    localparam logic [1:0] MODE_ASSIGN = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [KEY_BITS-1:0]   range_begin;
        logic signed [KEY_BITS-1:0]   range_end;
        logic [VALUE_BITS-1:0]        assign_value;
        logic signed [KEY_BITS-1:0]   lookup_key;
    } ivm_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] found_value;
        logic                  table_full;
        logic [4:0]            entries_used;
    } ivm_out_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0]      value;
    } ivm_entry_t;

    typedef struct packed {
        logic       shift;
        logic       commit;
        logic       wr_en;
        ivm_entry_t wr_entry;
    } ivm_cell_ctrl_t;

endpackage

// ===== rtl/ivm_cell.sv =====
// One table cell: a live breakpoint that rotates along the ring and a staged
// breakpoint built during an assign. Depends on ivm_pkg.
module ivm_cell #(
    parameter int IDX_BITS = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                    aclk,
    input  ivm_pkg::ivm_cell_ctrl_t ctrl,
    input  logic [IDX_BITS-1:0]     wr_idx,
    input  ivm_pkg::ivm_entry_t     from_next,
    output ivm_pkg::ivm_entry_t     entry
);
    import ivm_pkg::*;

    ivm_entry_t live_reg;
    ivm_entry_t staged_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            live_reg <= staged_reg;
        end else if (ctrl.shift) begin
            live_reg <= from_next;
        end
        if (ctrl.wr_en && wr_idx == IDX_BITS'(CELL_IDX)) begin
            staged_reg <= ctrl.wr_entry;
        end
    end

    assign entry = live_reg;

endmodule

// ===== rtl/interval_value_map_core.sv =====
// Interval value map: a ring of ENTRIES cells holding sorted breakpoints.
// Sequence: a clear, an unused mode or an empty assign goes straight from acceptance to the
// done state and its registered result; a lookup or a nonempty assign first makes one full
// ring turn, with an assign also inserting both range ends, then a finishing step and the result register.
// Throughput: one item at a time; the next is accepted the cycle after the result registers,
// later while an older result waits. Reset (aresetn, synchronous) empties table, default 0.
module interval_value_map_core #(
    parameter int ENTRIES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ivm_pkg::ivm_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ivm_pkg::ivm_out_t m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ivm_pkg::VALUE_BITS-1:0] cfg_data
);
    import ivm_pkg::*;

    localparam int CW = $clog2(ENTRIES + 3);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                     state_reg, state_next;
    logic [VALUE_BITS-1:0]      default_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              out_reg, out_next;
    logic [VALUE_BITS-1:0]      prev_reg, prev_next;
    logic [VALUE_BITS-1:0]      ev_reg, ev_next;
    logic                       insb_reg, insb_next;
    logic                       inse_reg, inse_next;
    logic                       assign_reg;
    logic signed [KEY_BITS-1:0] kb_reg, ke_reg;
    logic [VALUE_BITS-1:0]      av_reg;
    logic [VALUE_BITS-1:0]      found_reg, found_next;
    logic                       full_reg, full_next;
    logic                       m_valid_reg;
    ivm_out_t                   m_data_reg;

    ivm_cell_ctrl_t             ctrl;
    logic                       emit;
    ivm_entry_t                 emit_entry;
    ivm_entry_t                 cell_q [ENTRIES];
    ivm_entry_t                 head;
    logic                       head_ok;

    assign head    = cell_q[0];
    assign head_ok = idx_reg < count_reg;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            ivm_cell #(.IDX_BITS(CW), .CELL_IDX(g)) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .wr_idx    (out_reg),
                .from_next (cell_q[(g + 1) % ENTRIES]),
                .entry     (cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        out_next    = out_reg;
        prev_next   = prev_reg;
        ev_next     = ev_reg;
        insb_next   = insb_reg;
        inse_next   = inse_reg;
        found_next  = found_reg;
        full_next   = full_reg;
        emit        = 1'b0;
        emit_entry  = head;
        ctrl        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next   = '0;
                    out_next   = '0;
                    prev_next  = default_reg;
                    ev_next    = default_reg;
                    found_next = '0;
                    full_next  = 1'b0;
                    insb_next  = s_data.mode != MODE_ASSIGN;
                    inse_next  = s_data.mode != MODE_ASSIGN;
                    case (s_data.mode)
                        MODE_ASSIGN: begin
                            if (s_data.range_begin < s_data.range_end) begin
                                state_next = ST_RUN;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_LOOKUP: state_next = ST_RUN;
                        MODE_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RUN: begin
                if (!insb_reg && (!head_ok || head.key >= kb_reg)) begin
                    emit       = 1'b1;
                    emit_entry = '{key: kb_reg, value: av_reg};
                    insb_next  = 1'b1;
                end else if (!inse_reg && (!head_ok || head.key > ke_reg)) begin
                    emit       = 1'b1;
                    emit_entry = '{key: ke_reg, value: ev_reg};
                    inse_next  = 1'b1;
                end else if (head_ok) begin
                    // ke_reg holds the lookup key during a lookup.
                    ctrl.shift = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    if (head.key <= ke_reg) begin
                        ev_next = head.value;
                    end
                    emit = assign_reg && (head.key < kb_reg || head.key > ke_reg);
                end else if (idx_reg < CW'(ENTRIES)) begin
                    // Finish the turn so every breakpoint is back in its cell.
                    ctrl.shift = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                    if (assign_reg) begin
                        full_next = out_reg > CW'(ENTRIES);
                        if (out_reg <= CW'(ENTRIES)) begin
                            ctrl.commit = 1'b1;
                            count_next  = out_reg;
                        end
                    end else begin
                        found_next = ev_reg;
                    end
                end
                // Canonical form: only value changes become breakpoints.
                if (emit && emit_entry.value != prev_reg) begin
                    ctrl.wr_en    = out_reg < CW'(ENTRIES);
                    ctrl.wr_entry = emit_entry;
                    out_next      = out_reg + 1'b1;
                    prev_next     = emit_entry.value;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            default_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                default_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg             <= 1'b1;
                m_data_reg.found_value  <= found_reg;
                m_data_reg.table_full   <= full_reg;
                m_data_reg.entries_used <= 5'(count_reg);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        idx_reg   <= idx_next;
        out_reg   <= out_next;
        prev_reg  <= prev_next;
        ev_reg    <= ev_next;
        insb_reg  <= insb_next;
        inse_reg  <= inse_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        if (state_reg == ST_IDLE && s_valid) begin
            assign_reg <= s_data.mode == MODE_ASSIGN;
            kb_reg     <= s_data.range_begin;
            av_reg     <= s_data.assign_value;
            ke_reg     <= (s_data.mode == MODE_ASSIGN) ? s_data.range_end
                                                       : s_data.lookup_key;
        end
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== bench/interval_value_map_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for interval_value_map_core: range assigns, lookups and clears
// are predicted by an in-bench copy of the breakpoint table. Depends on ivm_pkg.
module interval_value_map_core_tb;
    import ivm_pkg::*;

    localparam int ENTRIES = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ivm_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ivm_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [VALUE_BITS-1:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    interval_value_map_core #(.ENTRIES(ENTRIES)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predicted table state, keys kept as signed values.
    logic signed [KEY_BITS-1:0] bp_key [ENTRIES];
    logic [VALUE_BITS-1:0] bp_val [ENTRIES];
    int bp_count;
    logic [VALUE_BITS-1:0] dflt;

    ivm_in_t pending_items[$];
    ivm_out_t expected_results[$];
    int error_count = 0;
    int result_count = 0;
    int full_count = 0;
    int cycle_count = 0;
    int send_wait = 0;
    int recv_wait = 0;

    function automatic logic [VALUE_BITS-1:0] value_at(logic signed [KEY_BITS-1:0] k);
        logic [VALUE_BITS-1:0] v;
        v = dflt;
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] <= k) begin
                v = bp_val[i];
            end else begin
                break;
            end
        end
        return v;
    endfunction

    // Returns 1 when the assign would need more than ENTRIES breakpoints.
    function automatic bit assign_range(logic signed [KEY_BITS-1:0] kb,
                                        logic signed [KEY_BITS-1:0] ke,
                                        logic [VALUE_BITS-1:0] val);
        logic signed [KEY_BITS-1:0] tk [ENTRIES+2];
        logic [VALUE_BITS-1:0] tv [ENTRIES+2];
        logic [VALUE_BITS-1:0] end_val, prev;
        int n, kept;
        n = 0;
        kept = 0;
        if (kb >= ke) return 1'b0;
        end_val = value_at(ke);
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] < kb) begin
                tk[n] = bp_key[i];
                tv[n] = bp_val[i];
                n++;
            end
        end
        tk[n] = kb; tv[n] = val; n++;
        tk[n] = ke; tv[n] = end_val; n++;
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] > ke && n < ENTRIES + 2) begin
                tk[n] = bp_key[i];
                tv[n] = bp_val[i];
                n++;
            end
        end
        prev = dflt;
        for (int i = 0; i < n; i++) begin
            if (tv[i] != prev) begin
                tk[kept] = tk[i];
                tv[kept] = tv[i];
                kept++;
                prev = tv[i];
            end
        end
        if (kept > ENTRIES) return 1'b1;
        for (int i = 0; i < kept; i++) begin
            bp_key[i] = tk[i];
            bp_val[i] = tv[i];
        end
        bp_count = kept;
        return 1'b0;
    endfunction

    function automatic ivm_out_t predict_result(ivm_in_t item);
        ivm_out_t r;
        r = '0;
        case (item.mode)
            MODE_ASSIGN: begin
                r.table_full = assign_range(item.range_begin, item.range_end,
                                            item.assign_value);
            end
            MODE_LOOKUP: begin
                r.found_value = value_at(item.lookup_key);
            end
            MODE_CLEAR: begin
                bp_count = 0;
            end
            default: begin
            end
        endcase
        r.entries_used = 5'(bp_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Driver: presents queued items after a random gap per transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
                void'(pending_items.pop_front());
                send_wait <= $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
                if (pending_items.size() > 0 && send_wait == 0 && $urandom_range(0, 1)) begin
                    s_data <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items[0];
                end
            end
        end
    end

    // Monitor: random backpressure, compares each transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                ivm_out_t want;
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.found_value !== want.found_value)
                        report_mismatch("found_value", m_data.found_value, want.found_value);
                    if (m_data.table_full !== want.table_full)
                        report_mismatch("table_full", m_data.table_full, want.table_full);
                    if (m_data.entries_used !== want.entries_used)
                        report_mismatch("entries_used", m_data.entries_used,
                                        want.entries_used);
                    if (want.table_full) full_count++;
                end
                recv_wait <= $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("interval_value_map_core: mismatch");
            $finish;
        end
    end

    function automatic logic signed [KEY_BITS-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return $signed($urandom());
            1: return $signed(32'h8000_0000 + $urandom_range(0, 3));
            2: return $signed(32'h7FFF_FFFF - $urandom_range(0, 3));
            default: return $signed($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    function automatic ivm_in_t make_item(logic [1:0] mode, int kb, int ke, int v, int lk);
        ivm_in_t it;
        it.mode = mode;
        it.range_begin = kb;
        it.range_end = ke;
        it.assign_value = v[VALUE_BITS-1:0];
        it.lookup_key = lk;
        return it;
    endfunction

    function automatic ivm_in_t random_item();
        ivm_in_t it;
        int pick;
        it.range_begin = rand_key();
        it.range_end = rand_key();
        // Mostly proper ranges so the table fills and overflows.
        if ($urandom_range(0, 9) != 0 && it.range_begin > it.range_end) begin
            it.range_begin = it.range_end;
            it.range_end = rand_key();
        end
        it.assign_value = VALUE_BITS'($urandom_range(0, 3) == 0 ? $urandom()
                                                                : $urandom_range(0, 4));
        it.lookup_key = rand_key();
        pick = $urandom_range(0, 99);
        if (pick < 55) it.mode = MODE_ASSIGN;
        else if (pick < 92) it.mode = MODE_LOOKUP;
        else if (pick < 97) it.mode = MODE_CLEAR;
        else it.mode = 2'd3;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (ENTRIES + 10) @(posedge aclk);
    endtask

    task automatic write_default(logic [VALUE_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        dflt = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [VALUE_BITS-1:0] phase_defaults [4];
        phase_defaults = '{8'd0, 8'd255, 8'd2, 8'd128};
        bp_count = 0;
        dflt = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme keys, empty ranges, every mode, overflow.
        pending_items.push_back(make_item(MODE_LOOKUP, 0, 0, 0, 32'sh8000_0000));
        pending_items.push_back(make_item(MODE_ASSIGN, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                          255, 0));
        pending_items.push_back(make_item(MODE_LOOKUP, 0, 0, 0, 32'sh7FFF_FFFF));
        pending_items.push_back(make_item(MODE_LOOKUP, 0, 0, 0, 32'sh8000_0000));
        pending_items.push_back(make_item(MODE_ASSIGN, 5, 5, 7, 0));
        pending_items.push_back(make_item(MODE_ASSIGN, 9, 3, 7, 0));
        pending_items.push_back(make_item(MODE_ASSIGN, -4, 4, 0, 0));
        pending_items.push_back(make_item(MODE_ASSIGN, -4, 4, 0, 0));
        pending_items.push_back(make_item(2'd3, -1, 1, 255, -1));
        pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < 10; i++)
            pending_items.push_back(make_item(MODE_ASSIGN, 4 * i, 4 * i + 2, i + 1, 0));
        pending_items.push_back(make_item(MODE_LOOKUP, 0, 0, 0, 37));
        pending_items.push_back(make_item(MODE_LOOKUP, 0, 0, 0, 38));
        pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_default(phase_defaults[ph]);
            for (int i = 0; i < 310; i++) pending_items.push_back(random_item());
            drain();
        end

        $display("%0d results checked over 4 default settings, %0d refused assigns",
                 result_count, full_count);
        if (error_count == 0) begin
            $display("interval_value_map_core: match");
        end else begin
            $display("interval_value_map_core: mismatch");
        end
        $finish;
    end

endmodule
